// File: rtl/stts_pkg.sv
// Shared types and constants for the script token splitter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package stts_pkg;

  localparam int MAX_TOKEN = 1024;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LINE  = 2'd1;
  localparam logic [1:0] ERR_QUOTE = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       same;
    logic       nul;
    logic       space;
    logic       newline;
    logic       slash;
    logic       quote;
  } cls_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tbyte;
    logic        first;
    logic        last;
    logic [15:0] line;
    logic [1:0]  err;
  } res_t;

  typedef struct packed {
    logic       take;
    logic       stopped;
    logic [1:0] wr;
  } bstat_t;

endpackage

// File: rtl/stts_front.sv
// Front end: accepts text bytes, classifies them and queues them for the scanner.
// Depends on stts_pkg.
`timescale 1ns / 1ps

module stts_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         text_byte,
  input  logic               same_line_only,
  output stts_pkg::cls_t     item,
  output logic               item_valid,
  input  logic               item_take
);

  stts_pkg::cls_t                 q [stts_pkg::QDEPTH];
  logic [stts_pkg::QAW-1:0]       wp;
  logic [stts_pkg::QAW-1:0]       rp;
  logic [stts_pkg::QCW-1:0]       cnt;
  stts_pkg::cls_t                 cls;
  logic                           push_ok;
  logic                           pop_ok;

  assign full       = (cnt == stts_pkg::QCW'(stts_pkg::QDEPTH));
  assign item_valid = (cnt != '0);
  assign item       = q[rp];
  assign push_ok    = push & ~full;
  assign pop_ok     = item_take & item_valid;

  always_comb begin
    cls.text_byte = text_byte;
    cls.same      = same_line_only;
    cls.nul       = (text_byte == 8'd0);
    cls.space     = (text_byte != 8'd0) && (text_byte <= stts_pkg::CH_SPACE);
    cls.newline   = (text_byte == stts_pkg::CH_NL);
    cls.slash     = (text_byte == stts_pkg::CH_SLASH);
    cls.quote     = (text_byte == stts_pkg::CH_QUOTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push_ok) wp <= wp + 1'b1;
      if (pop_ok) rp <= rp + 1'b1;
      cnt <= cnt + stts_pkg::QCW'(push_ok) - stts_pkg::QCW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q[wp] <= cls;
  end

endmodule

// File: rtl/stts_back.sv
// Back end: scanner state machine that turns classified bytes into result items.
// Depends on stts_pkg; fed by stts_front, drains into stts_outq.
`timescale 1ns / 1ps

module stts_back #(
  parameter int MAX_TOKEN = stts_pkg::MAX_TOKEN
) (
  input  logic               clk,
  input  logic               rst,
  input  stts_pkg::cls_t     item,
  input  logic               item_valid,
  output logic               item_take,
  input  logic               room,
  output stts_pkg::res_t     r0,
  output stts_pkg::res_t     r1,
  output stts_pkg::bstat_t   stat
);

  localparam int LW = $clog2(MAX_TOKEN);
  localparam logic [LW-1:0] LEN_LAST = LW'(MAX_TOKEN - 1);

  localparam logic [2:0] M_SKIP    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_BARE    = 3'd3;
  localparam logic [2:0] M_QUOTE   = 3'd4;
  localparam logic [2:0] M_DONE    = 3'd5;
  localparam logic [2:0] M_HALT    = 3'd6;

  logic [2:0]    mode, mode_next;
  logic [7:0]    held_byte, held_byte_next;
  logic          held_valid, held_valid_next;
  logic          held_first, held_first_next;
  logic [LW-1:0] tlen, tlen_next;
  logic [15:0]   line;
  logic          bump;
  logic          v0, v1;
  logic          do_ext, do_skip, skip_slot1;
  logic          skip_v;
  stts_pkg::res_t skip_r;
  logic          wide;

  function automatic stts_pkg::res_t mk(logic [1:0] kind, logic [7:0] b, logic f, logic l,
                                        logic [15:0] ln, logic [1:0] e);
    stts_pkg::res_t r;
    r.kind  = kind;
    r.tbyte = b;
    r.first = f;
    r.last  = l;
    r.line  = ln;
    r.err   = e;
    return r;
  endfunction

  assign item_take = item_valid & room;
  assign wide      = ~item.nul & ~item.space;

  always_comb begin
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    held_first_next = held_first;
    tlen_next       = tlen;
    bump            = 1'b0;
    v0              = 1'b0;
    v1              = 1'b0;
    r0              = '0;
    r1              = '0;
    do_ext          = 1'b0;
    do_skip         = 1'b0;
    skip_slot1      = 1'b0;
    skip_v          = 1'b0;
    skip_r          = '0;

    case (mode)
      M_SKIP: begin
        do_skip = 1'b1;
      end
      M_SLASH, M_BARE: begin
        if (mode == M_SLASH && item.slash) begin
          held_valid_next = 1'b0;
          if (item.same) begin
            v0        = 1'b1;
            r0        = mk(stts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, line, stts_pkg::ERR_LINE);
            mode_next = M_HALT;
          end else begin
            mode_next = M_COMMENT;
          end
        end else if (wide) begin
          mode_next = M_BARE;
          do_ext    = 1'b1;
        end else begin
          v0              = 1'b1;
          r0              = mk(stts_pkg::KIND_BYTE, held_byte, held_first, 1'b1, line,
                               stts_pkg::ERR_NONE);
          held_valid_next = 1'b0;
          do_skip         = 1'b1;
          skip_slot1      = 1'b1;
        end
      end
      M_COMMENT: begin
        if (item.nul) begin
          do_skip = 1'b1;
        end else if (item.newline) begin
          bump      = 1'b1;
          mode_next = M_SKIP;
        end
      end
      M_QUOTE: begin
        if (item.nul) begin
          v0              = 1'b1;
          r0              = mk(stts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, line, stts_pkg::ERR_QUOTE);
          mode_next       = M_HALT;
          held_valid_next = 1'b0;
        end else if (item.quote) begin
          mode_next       = M_SKIP;
          v0              = 1'b1;
          held_valid_next = 1'b0;
          if (held_valid) begin
            r0 = mk(stts_pkg::KIND_BYTE, held_byte, held_first, 1'b1, line, stts_pkg::ERR_NONE);
          end else begin
            r0 = mk(stts_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b1, line, stts_pkg::ERR_NONE);
          end
        end else begin
          do_ext = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_ext) begin
      if (tlen == LEN_LAST) begin
        v0              = 1'b1;
        r0              = mk(stts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, line, stts_pkg::ERR_LONG);
        mode_next       = M_HALT;
        held_valid_next = 1'b0;
      end else begin
        tlen_next = tlen + 1'b1;
        if (held_valid) begin
          v0 = 1'b1;
          r0 = mk(stts_pkg::KIND_BYTE, held_byte, held_first, 1'b0, line, stts_pkg::ERR_NONE);
        end
        held_first_next = ~held_valid;
        held_byte_next  = item.text_byte;
        held_valid_next = 1'b1;
      end
    end

    if (do_skip) begin
      if (item.nul) begin
        skip_v = 1'b1;
        if (item.same) begin
          skip_r          = mk(stts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, line, stts_pkg::ERR_LINE);
          mode_next       = M_HALT;
          held_valid_next = 1'b0;
        end else begin
          skip_r    = mk(stts_pkg::KIND_END, 8'd0, 1'b0, 1'b0, line, stts_pkg::ERR_NONE);
          mode_next = M_DONE;
        end
      end else if (item.space) begin
        mode_next = M_SKIP;
        if (item.newline) begin
          if (item.same) begin
            skip_v          = 1'b1;
            skip_r          = mk(stts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, line,
                                 stts_pkg::ERR_LINE);
            mode_next       = M_HALT;
            held_valid_next = 1'b0;
          end else begin
            bump = 1'b1;
          end
        end
      end else if (item.quote) begin
        held_valid_next = 1'b0;
        held_first_next = 1'b1;
        tlen_next       = '0;
        mode_next       = M_QUOTE;
      end else begin
        held_byte_next  = item.text_byte;
        held_valid_next = 1'b1;
        held_first_next = 1'b1;
        tlen_next       = LW'(1);
        mode_next       = item.slash ? M_SLASH : M_BARE;
      end
      if (skip_slot1) begin
        v1 = skip_v;
        r1 = skip_r;
      end else begin
        v0 = skip_v;
        r0 = skip_r;
      end
    end
  end

  assign stat.take    = item_take;
  assign stat.stopped = (mode == M_DONE) || (mode == M_HALT);
  assign stat.wr      = {v1 & item_take, v0 & item_take};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_SKIP;
      held_valid <= 1'b0;
      held_first <= 1'b0;
      tlen       <= '0;
      line       <= 16'd1;
      held_byte  <= 8'd0;
    end else if (item_take) begin
      mode       <= mode_next;
      held_valid <= held_valid_next;
      held_first <= held_first_next;
      tlen       <= tlen_next;
      held_byte  <= held_byte_next;
      if (bump && line != stts_pkg::LINE_MAX) line <= line + 16'd1;
    end
  end

endmodule

// File: rtl/stts_outq.sv
// Result queue: takes up to two result items per cycle, hands out one per pop.
// Depends on stts_pkg.
`timescale 1ns / 1ps

module stts_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         wr,
  input  stts_pkg::res_t     r0,
  input  stts_pkg::res_t     r1,
  output logic               room,
  input  logic               pop,
  output logic               empty,
  output stts_pkg::res_t     head
);

  stts_pkg::res_t              q [stts_pkg::QDEPTH];
  logic [stts_pkg::QAW-1:0]    wp;
  logic [stts_pkg::QAW-1:0]    rp;
  logic [stts_pkg::QCW-1:0]    cnt;
  logic                        pop_ok;

  assign empty  = (cnt == '0);
  assign room   = (cnt <= stts_pkg::QCW'(stts_pkg::QDEPTH - 2));
  assign head   = q[rp];
  assign pop_ok = pop & ~empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + stts_pkg::QAW'(wr[0]) + stts_pkg::QAW'(wr[1]);
      if (pop_ok) rp <= rp + 1'b1;
      cnt <= cnt + stts_pkg::QCW'(wr[0]) + stts_pkg::QCW'(wr[1]) - stts_pkg::QCW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr[0]) q[wp] <= r0;
    if (wr[1]) q[wp + 1'b1] <= r1;
  end

endmodule

// File: rtl/script_token_splitter.sv
// Top level of the script token splitter: front queue, scanner, result queue.
// Depends on stts_pkg, stts_front, stts_back and stts_outq.
//
//   channel  | handshake        | fields
//   ---------+------------------+-------------------------------------------------
//   text in  | push / full      | text_byte, same_line_only
//   results  | pop / empty      | kind, token_byte, is_first, is_last, line_number,
//            |                  | error_code
//
// One text byte per cycle is taken while the front queue is not full; the scanner
// retires one queued byte per cycle while the result queue has room. The scanner
// reads the front queue head and writes its results into the result queue.
// A byte can give two results; the scanner waits whenever the result
// queue has fewer than two free entries, and the front queue fills behind it.
// Synchronous reset clears both queues and the scanner; after end of data or an
// error, bytes are still taken but give no result until reset.
`timescale 1ns / 1ps

module script_token_splitter #(
  parameter int MAX_TOKEN = stts_pkg::MAX_TOKEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        same_line_only,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  token_byte,
  output logic        is_first,
  output logic        is_last,
  output logic [15:0] line_number,
  output logic [1:0]  error_code
);

  stts_pkg::cls_t   item;
  logic             item_valid;
  logic             item_take;
  logic             room;
  stts_pkg::res_t   r0;
  stts_pkg::res_t   r1;
  stts_pkg::res_t   head;
  stts_pkg::bstat_t stat;

  stts_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .same_line_only (same_line_only),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take)
  );

  stts_back #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .room       (room),
    .r0         (r0),
    .r1         (r1),
    .stat       (stat)
  );

  stts_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (stat.wr),
    .r0    (r0),
    .r1    (r1),
    .room  (room),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign kind        = head.kind;
  assign token_byte  = head.tbyte;
  assign is_first    = head.first;
  assign is_last     = head.last;
  assign line_number = head.line;
  assign error_code  = head.err;

  a_take_room: assert property (@(posedge clk) disable iff (rst) stat.take |-> room)
    else $error("scanner advanced without room for two results");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    stat.stopped |=> stat.stopped)
    else $error("scanner left the stopped state without reset");

  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    stat.wr[1] |-> stat.wr[0])
    else $error("second result written without the first");

endmodule

// File: test/token_split_checker.sv
// Checker for the script token splitter: watches the text and result queues,
// predicts the results of every accepted text byte and compares them in order.
// Depends on stts_pkg; instantiated beside the block by tb_script_token_splitter.
`timescale 1ns / 1ps

module token_split_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  text_byte,
  input  logic        same_line_only,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind,
  input  logic [7:0]  token_byte,
  input  logic        is_first,
  input  logic        is_last,
  input  logic [15:0] line_number,
  input  logic [1:0]  error_code,
  output int          mismatches,
  output int          pending
);

  typedef enum logic [2:0] {
    SCAN_SKIP, SCAN_SLASH, SCAN_COMMENT, SCAN_BARE, SCAN_QUOTE, SCAN_DONE, SCAN_HALT
  } scan_e;

  scan_e          mode;
  logic [7:0]     held_b;
  logic           held_v;
  logic           held_f;
  int unsigned    tok_len;
  logic [15:0]    line_cnt;
  stts_pkg::res_t split_q[$];
  int             errs = 0;

  function automatic void emit_result(input logic [1:0] k, input logic [7:0] b,
                                      input logic f, input logic l, input logic [1:0] e);
    stts_pkg::res_t r;
    r.kind  = k;
    r.tbyte = b;
    r.first = f;
    r.last  = l;
    r.line  = line_cnt;
    r.err   = e;
    split_q.push_back(r);
  endfunction

  function automatic void stop_scan(input logic [1:0] e);
    mode   = SCAN_HALT;
    held_v = 1'b0;
    emit_result(stts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0, e);
  endfunction

  function automatic void count_line();
    if (line_cnt != stts_pkg::LINE_MAX) line_cnt = line_cnt + 16'd1;
  endfunction

  // hold the new byte; the previously held one is now known not to be last
  function automatic void grow_token(input logic [7:0] b);
    tok_len++;
    if (tok_len >= stts_pkg::MAX_TOKEN) begin
      stop_scan(stts_pkg::ERR_LONG);
      return;
    end
    if (held_v) emit_result(stts_pkg::KIND_BYTE, held_b, held_f, 1'b0, stts_pkg::ERR_NONE);
    held_f = !held_v;
    held_b = b;
    held_v = 1'b1;
  endfunction

  function automatic void start_position(input logic [7:0] b, input logic s);
    if (b == 8'h00) begin
      if (s) begin
        stop_scan(stts_pkg::ERR_LINE);
      end else begin
        mode = SCAN_DONE;
        emit_result(stts_pkg::KIND_END, 8'h00, 1'b0, 1'b0, stts_pkg::ERR_NONE);
      end
      return;
    end
    if (b <= stts_pkg::CH_SPACE) begin
      mode = SCAN_SKIP;
      if (b == stts_pkg::CH_NL) begin
        if (s) stop_scan(stts_pkg::ERR_LINE);
        else count_line();
      end
      return;
    end
    held_v  = 1'b0;
    held_f  = 1'b1;
    tok_len = 0;
    if (b == stts_pkg::CH_QUOTE) begin
      mode = SCAN_QUOTE;
      return;
    end
    mode = (b == stts_pkg::CH_SLASH) ? SCAN_SLASH : SCAN_BARE;
    grow_token(b);
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic s);
    case (mode)
      SCAN_SKIP: start_position(b, s);
      SCAN_SLASH, SCAN_BARE: begin
        if (mode == SCAN_SLASH && b == stts_pkg::CH_SLASH) begin
          held_v = 1'b0;
          if (s) stop_scan(stts_pkg::ERR_LINE);
          else mode = SCAN_COMMENT;
        end else if (b > stts_pkg::CH_SPACE) begin
          mode = SCAN_BARE;
          grow_token(b);
        end else begin
          emit_result(stts_pkg::KIND_BYTE, held_b, held_f, 1'b1, stts_pkg::ERR_NONE);
          held_v = 1'b0;
          mode   = SCAN_SKIP;
          start_position(b, s);
        end
      end
      SCAN_COMMENT: begin
        if (b == 8'h00) begin
          start_position(b, s);
        end else if (b == stts_pkg::CH_NL) begin
          count_line();
          mode = SCAN_SKIP;
        end
      end
      SCAN_QUOTE: begin
        if (b == 8'h00) begin
          stop_scan(stts_pkg::ERR_QUOTE);
        end else if (b == stts_pkg::CH_QUOTE) begin
          mode = SCAN_SKIP;
          if (held_v) begin
            held_v = 1'b0;
            emit_result(stts_pkg::KIND_BYTE, held_b, held_f, 1'b1, stts_pkg::ERR_NONE);
          end else begin
            emit_result(stts_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b1, stts_pkg::ERR_NONE);
          end
        end else begin
          grow_token(b);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    stts_pkg::res_t seen;
    stts_pkg::res_t want;
    if (rst) begin
      mode     = SCAN_SKIP;
      held_b   = 8'h00;
      held_v   = 1'b0;
      held_f   = 1'b0;
      tok_len  = 0;
      line_cnt = 16'd1;
      split_q.delete();
    end else begin
      if (pop && !empty) begin
        seen = {kind, token_byte, is_first, is_last, line_number, error_code};
        if (split_q.size() == 0) begin
          if (errs < 10)
            $display("unexpected result: kind=%0d byte=%02h first=%0b last=%0b line=%0d err=%0d",
                     seen.kind, seen.tbyte, seen.first, seen.last, seen.line, seen.err);
          errs++;
        end else begin
          want = split_q.pop_front();
          if (seen !== want) begin
            if (errs < 10) begin
              $display("mismatch: expected kind=%0d byte=%02h first=%0b last=%0b line=%0d err=%0d",
                       want.kind, want.tbyte, want.first, want.last, want.line, want.err);
              $display("          actual   kind=%0d byte=%02h first=%0b last=%0b line=%0d err=%0d",
                       seen.kind, seen.tbyte, seen.first, seen.last, seen.line, seen.err);
            end
            errs++;
          end
        end
      end
      if (push && !full) split_byte(text_byte, same_line_only);
    end
    mismatches <= errs;
    pending    <= split_q.size();
  end

endmodule

// File: test/tb_script_token_splitter.sv
// Top of the script token splitter testbench: clock, reset, text stimulus and
// result pop stalls; verdict from token_split_checker. Depends on stts_pkg,
// token_split_checker and script_token_splitter.
`timescale 1ns / 1ps

module tb_script_token_splitter;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        same_line_only = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  kind;
  logic [7:0]  token_byte;
  logic        is_first;
  logic        is_last;
  logic [15:0] line_number;
  logic [1:0]  error_code;
  int          mismatches;
  int          pending;
  int          stall_cycles = 0;
  int          pop_hold = 0;
  int          sent = 0;
  logic        calm = 1'b0;

  always #5 clk = ~clk;

  script_token_splitter dut (.*);
  token_split_checker   u_checker (.*);

  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      pop_hold <= $urandom_range(0, 8);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push           <= 1'b1;
    text_byte      <= b;
    same_line_only <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string txt, input logic s);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], s);
  endtask

  // no opening quote and no double slash, so the run stays a bare token
  task automatic send_bare(input int unsigned len);
    logic [7:0] b;
    logic [7:0] lead;
    lead = 8'h00;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(33, 255));
      if (i == 0 && b == stts_pkg::CH_QUOTE) b = 8'h41;
      if (i == 0) lead = b;
      if (i == 1 && lead == stts_pkg::CH_SLASH && b == stts_pkg::CH_SLASH) b = 8'h42;
      send_byte(b, coin());
    end
  endtask

  task automatic send_gap();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      b = ($urandom_range(0, 3) == 0) ? stts_pkg::CH_NL : 8'($urandom_range(1, 32));
      send_byte(b, (b == stts_pkg::CH_NL) ? 1'b0 : coin());
    end
  endtask

  task automatic send_segment();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_bare(len);
      send_gap();
    end else if (pick < 6) begin
      send_byte(stts_pkg::CH_QUOTE, coin());
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (len) begin
        b = 8'($urandom_range(1, 255));
        if (b == stts_pkg::CH_QUOTE) b = 8'h71;
        send_byte(b, coin());
      end
      send_byte(stts_pkg::CH_QUOTE, coin());
      if (coin()) send_gap();
    end else if (pick == 6) begin
      send_byte(stts_pkg::CH_SLASH, coin());
      send_byte(stts_pkg::CH_SLASH, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(1, 255));
        if (b == stts_pkg::CH_NL) b = 8'h63;
        send_byte(b, coin());
      end
      send_byte(stts_pkg::CH_NL, coin());
    end else begin
      send_gap();
    end
  endtask

  // one terminating sequence, then bytes the stopped block must ignore
  task automatic send_ending();
    int unsigned lead;
    lead = $urandom_range(0, 2);
    case ($urandom_range(0, 4))
      0: begin
        if (lead == 1) begin
          send_bare($urandom_range(1, 4));
        end else if (lead == 2) begin
          send_byte(stts_pkg::CH_SLASH, coin());
          send_byte(stts_pkg::CH_SLASH, 1'b0);
          send_byte(8'h78, coin());
        end
        send_byte(8'h00, coin());
      end
      1: begin
        if (lead != 0) send_bare($urandom_range(1, 4));
        send_byte(stts_pkg::CH_NL, 1'b1);
      end
      2: begin
        send_byte(stts_pkg::CH_SLASH, coin());
        send_byte(stts_pkg::CH_SLASH, 1'b1);
      end
      3: begin
        send_byte(stts_pkg::CH_QUOTE, coin());
        repeat ($urandom_range(0, 5)) send_byte(8'h61, coin());
        send_byte(8'h00, coin());
      end
      default: begin
        if (coin()) begin
          send_bare(stts_pkg::MAX_TOKEN);
        end else begin
          send_byte(stts_pkg::CH_QUOTE, coin());
          repeat (stts_pkg::MAX_TOKEN) send_byte(8'($urandom_range(35, 255)), coin());
        end
      end
    endcase
    repeat (8) send_byte(8'($urandom_range(0, 255)), coin());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_text("!\377 / /a/b\001", 1'b1);
    send_text("\"\"\"\n\001\"// c\n\tz\n ", 1'b0);
    send_bare(stts_pkg::MAX_TOKEN - 1);
    send_gap();

    push <= 1'b0;
    do @(posedge clk); while (pending != 0);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      calm <= (sent >= RANDOM_BYTES * 5 / 6);
      send_segment();
    end
    calm <= 1'b1;
    send_ending();

    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
